>>> hw/rtl/ttb_pkg.sv
// shared types, command codes and the expiry test for the timeout timer bank
package ttb_pkg;

    localparam int DEF_CHANNELS   = 16;
    localparam int DEF_TICK_WIDTH = 32;

    localparam int CMD_W   = 3;
    localparam int CHF_W   = 8;
    localparam int LEN_W   = 32;
    localparam int NOW_W   = 32;

    // most expiry results one check request may report
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_ASSIGN  = 3'd0;
    localparam t_cmd CMD_RESTART = 3'd1;
    localparam t_cmd CMD_CLEAR   = 3'd2;
    localparam t_cmd CMD_CHECK   = 3'd3;
    localparam t_cmd CMD_QUERY   = 3'd4;

    // wrap-aware expiry test on start, deadline and now
    function automatic logic ttb_expired(logic [63:0] s, logic [63:0] d, logic [63:0] n);
        logic res;
        if (s > d) begin
            res = (n < s) && (n >= d);
        end else begin
            res = (n < s) || (n >= d);
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/ttb_chan_mem.sv
// per-channel start, deadline and length store, one write and one registered read port
module ttb_chan_mem #(
    parameter int DEPTH = ttb_pkg::DEF_CHANNELS,
    parameter int AW    = 4,
    parameter int DW    = 96
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/ttb_tick_unit.sv
// shared tick arithmetic: deadline sum and wrap-aware expiry compare
module ttb_tick_unit #(
    parameter int TICK_WIDTH = ttb_pkg::DEF_TICK_WIDTH
) (
    input  logic [TICK_WIDTH-1:0]      i_now,
    input  logic [ttb_pkg::LEN_W-1:0]  i_len,
    input  logic [TICK_WIDTH-1:0]      i_start,
    input  logic [TICK_WIDTH-1:0]      i_deadline,
    output logic [TICK_WIDTH-1:0]      o_sum,
    output logic                       o_expired
);

    logic [63:0] len_64;

    // length taken modulo the tick range, so the sum wraps the same way
    assign len_64    = {32'd0, i_len};
    assign o_sum     = i_now + len_64[TICK_WIDTH-1:0];
    assign o_expired = ttb_pkg::ttb_expired(64'(i_start), 64'(i_deadline), 64'(i_now));

endmodule

>>> hw/rtl/timeout_timer_bank.sv
// top level of the timeout timer bank: sequencer, enable bits and result register
//
// A bank of CHANNELS one-shot timeout channels driven by single-cycle requests.
// A request is taken when start is high and busy is low. Assign, clear, query
// and out-of-range requests finish in the cycle they are taken and put their
// one result on the outputs in the following cycle; busy stays low. Restart
// passes through the S_RST_WR state, as the stored length must first come out
// of the channel memory, whose read port is registered. A check request walks
// the channels in index order through that single read port and the shared
// tick unit, one channel a cycle, and ends early when the cap of MAX_RESULTS
// expiries is reached. Each result shows on the outputs for exactly one
// cycle, flagged by o_strobe: there is no back-pressure, so the receiver must
// take it then. For a check, each expiry is reported only after the next one
// is found or the scan ends, as the block holds one result back until it
// knows whether it is the final one (o_last). A check with nothing expired
// gives no result at all; unused command codes are dropped silently. The
// channel memory needs no clearing after reset: only the enable flip-flops
// are cleared, and a disabled channel's stored ticks are never consulted.
module timeout_timer_bank #(
    parameter int CHANNELS   = ttb_pkg::DEF_CHANNELS,
    parameter int TICK_WIDTH = ttb_pkg::DEF_TICK_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ttb_pkg::CMD_W-1:0]   i_cmd,
    input  logic [ttb_pkg::CHF_W-1:0]   i_channel,
    input  logic [ttb_pkg::LEN_W-1:0]   i_timeout_ticks,
    input  logic [ttb_pkg::NOW_W-1:0]   i_now_tick,
    output logic                        o_strobe,
    output logic                        o_status,
    output logic                        o_expired,
    output logic [ttb_pkg::CHF_W-1:0]   o_result_channel,
    output logic                        o_active,
    output logic                        o_last
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MEM_W = 2 * TICK_WIDTH + ttb_pkg::LEN_W;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);
    localparam logic [ttb_pkg::CNT_W-1:0] CNT_CAP = ttb_pkg::CNT_W'(ttb_pkg::MAX_RESULTS - 1);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RST_WR = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FLUSH  = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [CHANNELS-1:0]         r_en, n_en;
    logic [CH_W-1:0]             r_ch, n_ch;
    logic [TICK_WIDTH-1:0]       r_now, n_now;

    // scan pipeline: read issue, then evaluate in the cycle after
    logic [CH_W-1:0]             r_idx, n_idx;
    logic                        r_issue, n_issue;
    logic                        r_ev_v, n_ev_v;
    logic [CH_W-1:0]             r_ev_idx, n_ev_idx;
    logic [ttb_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                        r_pend_v, n_pend_v;
    logic [CH_W-1:0]             r_pend_ch, n_pend_ch;

    // result register
    logic                        r_strobe, n_strobe;
    logic                        r_status, n_status;
    logic                        r_expired, n_expired;
    logic [ttb_pkg::CHF_W-1:0]   r_rch, n_rch;
    logic                        r_active, n_active;
    logic                        r_last, n_last;

    // memory and shared unit hookup
    logic                        mem_we;
    logic [CH_W-1:0]             mem_waddr;
    logic [MEM_W-1:0]            mem_wdata;
    logic [CH_W-1:0]             mem_raddr;
    logic [MEM_W-1:0]            mem_rdata;
    logic [TICK_WIDTH-1:0]       rd_start;
    logic [TICK_WIDTH-1:0]       rd_deadline;
    logic [ttb_pkg::LEN_W-1:0]   rd_len;
    logic [TICK_WIDTH-1:0]       unit_now;
    logic [ttb_pkg::LEN_W-1:0]   unit_len;
    logic [TICK_WIDTH-1:0]       unit_sum;
    logic                        unit_exp;

    // request decode
    logic                        accept;
    logic                        in_range;
    logic [CH_W-1:0]             in_idx;
    logic [63:0]                 now_64;
    logic [TICK_WIDTH-1:0]       now_in;
    logic                        hit;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign in_range = ({1'b0, i_channel} < 9'(CHANNELS));
    assign in_idx   = i_channel[CH_W-1:0];
    assign now_64   = {32'd0, i_now_tick};
    assign now_in   = now_64[TICK_WIDTH-1:0];

    assign rd_start    = mem_rdata[MEM_W-1 -: TICK_WIDTH];
    assign rd_deadline = mem_rdata[MEM_W-TICK_WIDTH-1 -: TICK_WIDTH];
    assign rd_len      = mem_rdata[ttb_pkg::LEN_W-1:0];

    ttb_chan_mem #(
        .DEPTH (CHANNELS),
        .AW    (CH_W),
        .DW    (MEM_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ttb_tick_unit #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_unit (
        .i_now      (unit_now),
        .i_len      (unit_len),
        .i_start    (rd_start),
        .i_deadline (rd_deadline),
        .o_sum      (unit_sum),
        .o_expired  (unit_exp)
    );

    always_comb begin
        n_state   = r_state;
        n_en      = r_en;
        n_ch      = r_ch;
        n_now     = r_now;
        n_idx     = r_idx;
        n_issue   = r_issue;
        n_ev_v    = 1'b0;
        n_ev_idx  = r_ev_idx;
        n_cnt     = r_cnt;
        n_pend_v  = r_pend_v;
        n_pend_ch = r_pend_ch;

        n_strobe  = 1'b0;
        n_status  = 1'b0;
        n_expired = 1'b0;
        n_rch     = r_rch;
        n_active  = 1'b0;
        n_last    = 1'b0;

        mem_we    = 1'b0;
        mem_waddr = r_ch;
        mem_raddr = in_idx;
        unit_now  = now_in;
        unit_len  = i_timeout_ticks;
        mem_wdata = {now_in, unit_sum, i_timeout_ticks};
        hit       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_now = now_in;
                    n_ch  = in_idx;
                    if (i_cmd == ttb_pkg::CMD_CHECK) begin
                        n_state  = S_SCAN;
                        n_idx    = '0;
                        n_issue  = 1'b1;
                        n_cnt    = '0;
                        n_pend_v = 1'b0;
                    end else if (i_cmd > ttb_pkg::CMD_QUERY) begin
                        // unused code: no result, no change
                        n_state = S_IDLE;
                    end else if (!in_range) begin
                        n_strobe = 1'b1;
                        n_status = 1'b1;
                        n_rch    = i_channel;
                        n_last   = 1'b1;
                    end else if (i_cmd == ttb_pkg::CMD_RESTART) begin
                        // stored length comes out of memory next cycle
                        n_state = S_RST_WR;
                    end else begin
                        n_strobe = 1'b1;
                        n_rch    = i_channel;
                        n_last   = 1'b1;
                        priority if (i_cmd == ttb_pkg::CMD_ASSIGN) begin
                            if (i_timeout_ticks != '0) begin
                                mem_we         = 1'b1;
                                mem_waddr      = in_idx;
                                n_en[in_idx]   = 1'b1;
                                n_active       = 1'b1;
                            end else begin
                                n_en[in_idx]   = 1'b0;
                            end
                        end else if (i_cmd == ttb_pkg::CMD_CLEAR) begin
                            n_en[in_idx] = 1'b0;
                        end else begin
                            n_active = r_en[in_idx];
                        end
                    end
                end
            end

            S_RST_WR: begin
                unit_now  = r_now;
                unit_len  = rd_len;
                mem_wdata = {r_now, unit_sum, rd_len};
                mem_we    = r_en[r_ch];
                n_strobe  = 1'b1;
                n_rch     = ttb_pkg::CHF_W'(r_ch);
                n_active  = r_en[r_ch];
                n_last    = 1'b1;
                n_state   = S_IDLE;
            end

            S_SCAN: begin
                mem_raddr = r_idx;
                unit_now  = r_now;
                unit_len  = rd_len;
                if (r_issue) begin
                    n_idx    = r_idx + CH_W'(1);
                    n_ev_idx = r_idx;
                    n_ev_v   = 1'b1;
                    if (r_idx == LAST_CH) begin
                        n_issue = 1'b0;
                    end
                end
                hit = r_ev_v && r_en[r_ev_idx] && unit_exp;
                if (hit) begin
                    n_en[r_ev_idx] = 1'b0;
                    n_cnt          = r_cnt + ttb_pkg::CNT_W'(1);
                    n_pend_v       = 1'b1;
                    n_pend_ch      = r_ev_idx;
                    // an earlier expiry is now known not to be the final one
                    if (r_pend_v) begin
                        n_strobe  = 1'b1;
                        n_expired = 1'b1;
                        n_rch     = ttb_pkg::CHF_W'(r_pend_ch);
                    end
                end
                if (r_ev_v && ((r_ev_idx == LAST_CH) || (hit && (r_cnt == CNT_CAP)))) begin
                    n_state = S_FLUSH;
                    n_issue = 1'b0;
                end
            end

            S_FLUSH: begin
                if (r_pend_v) begin
                    n_strobe  = 1'b1;
                    n_expired = 1'b1;
                    n_rch     = ttb_pkg::CHF_W'(r_pend_ch);
                    n_last    = 1'b1;
                end
                n_pend_v = 1'b0;
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_en     <= '0;
            r_issue  <= 1'b0;
            r_ev_v   <= 1'b0;
            r_cnt    <= '0;
            r_pend_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_en     <= n_en;
            r_issue  <= n_issue;
            r_ev_v   <= n_ev_v;
            r_cnt    <= n_cnt;
            r_pend_v <= n_pend_v;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ch      <= n_ch;
        r_now     <= n_now;
        r_idx     <= n_idx;
        r_ev_idx  <= n_ev_idx;
        r_pend_ch <= n_pend_ch;
        r_status  <= n_status;
        r_expired <= n_expired;
        r_rch     <= n_rch;
        r_active  <= n_active;
        r_last    <= n_last;
    end

    assign o_strobe         = r_strobe;
    assign o_status         = r_status;
    assign o_expired        = r_expired;
    assign o_result_channel = r_rch;
    assign o_active         = r_active;
    assign o_last           = r_last;

endmodule

>>> hw/rtl/ttb_checker.sv
// port-level checks on the timeout timer bank, bound to its top level
module ttb_checker #(
    parameter int CHANNELS = ttb_pkg::DEF_CHANNELS
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_strobe,
    input logic                       o_status,
    input logic                       o_expired,
    input logic [ttb_pkg::CHF_W-1:0]  o_result_channel,
    input logic                       o_active,
    input logic                       o_last
);

    // an expiry report is never an error and always leaves the channel disarmed
    a_exp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_expired) |-> (!o_status && !o_active))
        else $error("expiry result with status or active set");

    // an out-of-range request gives a single final result naming a bad channel
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status) |->
            (o_last && !o_expired && !o_active && ({1'b0, o_result_channel} >= 9'(CHANNELS))))
        else $error("malformed out-of-range result");

    // further expiry reports still to come means the scan is still running
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_expired && !o_last) |-> busy)
        else $error("non-final expiry result while idle");

    // the cycle after a request is taken never carries an expiry report
    a_no_early_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !(o_strobe && o_expired))
        else $error("expiry result right after a request was taken");

endmodule

bind timeout_timer_bank ttb_checker #(
    .CHANNELS (CHANNELS)
) u_ttb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_strobe         (o_strobe),
    .o_status         (o_status),
    .o_expired        (o_expired),
    .o_result_channel (o_result_channel),
    .o_active         (o_active),
    .o_last           (o_last)
);
